>>> hdl/swm_pkg.sv
// Shared constants and types for the sliding window minimum block.
`default_nettype none

package swm_pkg;

  localparam int MAX_PERIOD   = 64;
  localparam int SAMPLE_WIDTH = 32;
  localparam int ADDR_W       = $clog2(MAX_PERIOD);
  localparam int CNT_W        = $clog2(MAX_PERIOD + 1);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [ADDR_W-1:0]              addr_t;
  typedef logic [CNT_W-1:0]               cnt_t;

endpackage

`default_nettype wire

>>> hdl/swm_if.sv
// Valid/ready channel interfaces for the sample input and the minimum output.
`default_nettype none

interface swm_in_if;
  logic             valid;
  logic             ready;
  swm_pkg::sample_t sample;
  logic             last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink (input valid, input sample, input last_sample, output ready);
endinterface

interface swm_out_if;
  logic             valid;
  logic             ready;
  swm_pkg::sample_t window_min;

  modport source (output valid, output window_min, input ready);
  modport sink (input valid, input window_min, output ready);
endinterface

`default_nettype wire

>>> hdl/swm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module swm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/sliding_window_minimum.sv
// Top level of the sliding window minimum block.
// Keeps the samples of the current series in a 64-entry ring and, once
// window_period samples have been seen, returns the minimum of the latest
// window_period samples for each sample (newest sample wins ties). A sample
// that yields no result is written to the ring and counted. A sample whose
// minimum is still inside the window is compared against the held minimum
// and the result loaded into the output register. When the held minimum
// leaves the window, or none is held yet, the ring is rescanned oldest to
// newest through its single read port, one entry per cycle, before that
// load. The output register lets the block take the next sample while a
// result waits. window_period values of 0 act as 1, values above 64 act as
// 64; write it only while the block is idle. last_sample ends the series
// and restarts the counters after its result, or at once if it has none.
`default_nettype none

module sliding_window_minimum (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire swm_pkg::cnt_t cfg_wdata,
  swm_in_if.sink             in_if,
  swm_out_if.source          out_if
);

  import swm_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_PUSH} state_t;

  state_t  state_r, state_nxt;
  addr_t   wslot_r, wslot_nxt;
  cnt_t    seen_r, seen_nxt;
  sample_t cur_min_r, cur_min_nxt;
  cnt_t    min_age_r, min_age_nxt;
  logic    last_r, last_nxt;
  addr_t   rd_age_r, rd_age_nxt;
  logic    issue_r, issue_nxt;
  logic    cmp_valid_r, cmp_valid_nxt;
  addr_t   cmp_age_r, cmp_age_nxt;
  logic    first_r, first_nxt;
  logic    out_valid_r, out_valid_nxt;
  sample_t out_data_r;
  cnt_t    period_r;

  cnt_t    period;
  cnt_t    period_m1;
  cnt_t    seen_inc;
  cnt_t    age_inc;
  logic    in_xfer;
  logic    load_out;
  addr_t   raddr;
  sample_t ram_rdata;
  sample_t cmp_lhs;
  logic    cmp_le;

  assign in_xfer          = in_if.valid && in_if.ready;
  assign in_if.ready      = (state_r == ST_IDLE);
  assign out_if.valid     = out_valid_r;
  assign out_if.window_min = out_data_r;
  assign raddr            = wslot_r - addr_t'(1) - rd_age_r;

  // One signed compare against the held minimum, shared by intake and rescan.
  assign cmp_lhs = (state_r == ST_SCAN) ? ram_rdata : in_if.sample;
  assign cmp_le  = (cmp_lhs <= cur_min_r);

  swm_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (MAX_PERIOD)
  ) u_ring (
    .clk   (clk),
    .we    (in_xfer),
    .waddr (wslot_r),
    .wdata (in_if.sample),
    .re    (issue_r),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // Clamp the period register into 1..MAX_PERIOD.
  always_comb begin
    if (period_r == '0) begin
      period = cnt_t'(1);
    end else if (period_r > cnt_t'(MAX_PERIOD)) begin
      period = cnt_t'(MAX_PERIOD);
    end else begin
      period = period_r;
    end
    period_m1 = period - cnt_t'(1);
    seen_inc  = (seen_r < cnt_t'(MAX_PERIOD)) ? seen_r + cnt_t'(1) : seen_r;
    age_inc   = (min_age_r != '0) ? min_age_r + cnt_t'(1) : '0;
  end

  always_comb begin
    state_nxt     = state_r;
    wslot_nxt     = wslot_r;
    seen_nxt      = seen_r;
    cur_min_nxt   = cur_min_r;
    min_age_nxt   = min_age_r;
    last_nxt      = last_r;
    rd_age_nxt    = rd_age_r;
    issue_nxt     = issue_r;
    cmp_valid_nxt = 1'b0;
    cmp_age_nxt   = cmp_age_r;
    first_nxt     = first_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    load_out      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          wslot_nxt = wslot_r + addr_t'(1);
          seen_nxt  = seen_inc;
          last_nxt  = in_if.last_sample;
          if (seen_inc >= period) begin
            if (age_inc == '0 || (age_inc - cnt_t'(1)) >= period) begin
              // Held minimum expired: rescan the window from its oldest entry.
              state_nxt  = ST_SCAN;
              rd_age_nxt = period_m1[ADDR_W-1:0];
              issue_nxt  = 1'b1;
              first_nxt  = 1'b1;
            end else begin
              state_nxt = ST_PUSH;
              if (cmp_le) begin
                cur_min_nxt = in_if.sample;
                min_age_nxt = cnt_t'(1);
              end else begin
                min_age_nxt = age_inc;
              end
            end
          end else begin
            min_age_nxt = '0;
            if (in_if.last_sample) begin
              wslot_nxt   = '0;
              seen_nxt    = '0;
              cur_min_nxt = '0;
            end
          end
        end
      end

      ST_SCAN: begin
        if (issue_r) begin
          cmp_valid_nxt = 1'b1;
          cmp_age_nxt   = rd_age_r;
          if (rd_age_r == '0) begin
            issue_nxt = 1'b0;
          end else begin
            rd_age_nxt = rd_age_r - addr_t'(1);
          end
        end
        if (cmp_valid_r) begin
          first_nxt = 1'b0;
          if (first_r || cmp_le) begin
            cur_min_nxt = ram_rdata;
            min_age_nxt = cnt_t'(cmp_age_r) + cnt_t'(1);
          end
          if (cmp_age_r == '0) begin
            state_nxt = ST_PUSH;
          end
        end
      end

      ST_PUSH: begin
        if (!out_valid_r || out_if.ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (last_r) begin
            wslot_nxt   = '0;
            seen_nxt    = '0;
            cur_min_nxt = '0;
            min_age_nxt = '0;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wslot_r     <= '0;
      seen_r      <= '0;
      cur_min_r   <= '0;
      min_age_r   <= '0;
      last_r      <= 1'b0;
      issue_r     <= 1'b0;
      cmp_valid_r <= 1'b0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
      period_r    <= cnt_t'(1);
    end else begin
      state_r     <= state_nxt;
      wslot_r     <= wslot_nxt;
      seen_r      <= seen_nxt;
      cur_min_r   <= cur_min_nxt;
      min_age_r   <= min_age_nxt;
      last_r      <= last_nxt;
      issue_r     <= issue_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        period_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_age_r  <= rd_age_nxt;
    cmp_age_r <= cmp_age_nxt;
    if (load_out) begin
      out_data_r <= cur_min_r;
    end
  end

endmodule

`default_nettype wire

>>> hdl/swm_chk.sv
// Port-level checks for the sliding window minimum block, bound to its top level.
`default_nettype none

module swm_chk (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire swm_pkg::sample_t window_min
);

  // Reset leaves the block idle with no result pending.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (in_ready && !out_valid))
    else $error("block not idle after reset");

  // A new result is loaded only in a cycle where input was held off.
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a busy cycle");

  // A result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(window_min)))
    else $error("stalled result changed");

  // An accepted sample, with no result pending, never shows up as a result in the cycle after it is taken.
  a_no_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !out_valid) |=> !out_valid)
    else $error("result bypassed the compare step");

endmodule

bind sliding_window_minimum swm_chk u_swm_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .window_min (out_if.window_min)
);

`default_nettype wire
